// ===== hw/rtl/mma_pkg.sv =====
// Package for the matrix multiply-accumulate engine: payload types and codes.
package mma_pkg;

    localparam int unsigned IDX_W   = 4;
    localparam int unsigned OPND_W  = 16;
    localparam int unsigned ACC_W   = 48;
    localparam int unsigned CFG_W   = 5;
    localparam int unsigned DIM_LIM = 16;

    typedef enum logic [1:0] {
        OP_LOAD_A  = 2'd0,
        OP_LOAD_B  = 2'd1,
        OP_LOAD_C  = 2'd2,
        OP_COMPUTE = 2'd3
    } opcode_t;

    typedef enum logic {
        CFG_ROWS_USED = 1'b0,
        CFG_DIM_USED  = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        opcode_t            opcode;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic signed [OPND_W-1:0] value;
    } in_word_t;

    typedef struct packed {
        logic [IDX_W-1:0]         out_row;
        logic [IDX_W-1:0]         out_col;
        logic signed [ACC_W-1:0]  out_value;
        logic                     last;
    } out_word_t;

    // Control broadcast from the sequencer to the cell chain.
    typedef struct packed {
        logic clear;   // load accumulator with C seed
        logic mac;     // accumulate the operands now present
        logic shift;   // move results one cell towards the output
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/mma_cell.sv =====
// One MAC cell: owns one result column, its B row bank and its C column bank.
module mma_cell #(
    parameter int unsigned MAX_DIM = 16,
    parameter int unsigned AW      = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mma_pkg::cell_ctrl_t               ctrl,
    input  logic                              ld_b,
    input  logic                              ld_c,
    input  logic                              wb,
    input  logic [AW-1:0]                     ld_addr,
    input  logic signed [mma_pkg::OPND_W-1:0] ld_value,
    input  logic [AW-1:0]                     b_addr,
    input  logic [AW-1:0]                     c_addr,
    input  logic signed [mma_pkg::OPND_W-1:0] a_in,
    input  logic signed [mma_pkg::ACC_W-1:0]  acc_in,
    output logic signed [mma_pkg::OPND_W-1:0] a_out,
    output logic signed [mma_pkg::ACC_W-1:0]  acc_out
);
    import mma_pkg::*;

    logic [OPND_W-1:0]          bank_b [MAX_DIM];
    logic [ACC_W-1:0]           bank_c [MAX_DIM];
    logic signed [OPND_W-1:0]   b_q;
    logic signed [ACC_W-1:0]    c_q;
    logic signed [OPND_W-1:0]   a_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic signed [2*OPND_W-1:0] prod;

    // Banks: registered reads, one address each per cycle.
    always_ff @(posedge clk)
    begin
        if (ld_b)
            bank_b[ld_addr] <= ld_value;
        if (ld_c)
            bank_c[ld_addr] <= ACC_W'(ld_value);
        else if (wb)
            bank_c[c_addr] <= acc_reg;
        b_q <= bank_b[b_addr];
        c_q <= bank_c[c_addr];
    end

    assign prod = a_in * b_q;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
            acc_next = c_q;
        else if (ctrl.mac)
            acc_next = acc_reg + ACC_W'(prod);
        else if (ctrl.shift)
            acc_next = acc_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg   <= '0;
            acc_reg <= '0;
        end
        else
        begin
            a_reg   <= a_in;
            acc_reg <= acc_next;
        end
    end

    assign a_out   = a_reg;
    assign acc_out = acc_reg;
endmodule

// ===== hw/rtl/matrix_multiply_accumulate.sv =====
// Top level of the matrix multiply-accumulate engine: stores, sequencer, cell chain.
//
// Loads leave busy low, so load words can follow back to back. A compute
// word for row r runs a chain of MAX_DIM MAC cells, cell j owning result
// column j together with row j of B and column j of C in its own banks.
// All stores are read through registers, so every read is issued in the
// cycle before its data is used. The A element of inner index k enters
// cell 0 and ripples one cell per cycle; cell j meets B[j][k] in the cycle
// the A element reaches it. The MAC phase is a seed step followed by the
// skew steps of the chain. The finished row then shifts out of cell 0, one
// column per cycle, strobed by out_valid with last on column dim-1; each
// cell writes its sum back to its C bank in the first drain cycle. A compute
// word therefore keeps busy high through the skew of the cell chain and the
// serial drain. A compute word for a row past rows_used, or with dim zero,
// emits nothing and leaves busy low like a load. Results cannot be held
// off; busy is high from accept to the final word.
module matrix_multiply_accumulate #(
    parameter int unsigned MAX_DIM = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  mma_pkg::in_word_t   in_word,
    output logic                out_valid,
    output mma_pkg::out_word_t  out_word,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [mma_pkg::CFG_W-1:0] cfg_data
);
    import mma_pkg::*;

    localparam int unsigned MW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int unsigned CW  = $clog2(2*MAX_DIM + 2);
    localparam int unsigned LIM = (MAX_DIM < DIM_LIM) ? MAX_DIM : DIM_LIM;

    // Configuration.
    logic [CFG_W-1:0] rows_reg, dim_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= CFG_W'(16);
            dim_reg  <= CFG_W'(16);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ROWS_USED: rows_reg <= cfg_data;
                CFG_DIM_USED:  dim_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [CFG_W-1:0] rows_eff, dim_eff;
    assign rows_eff = (rows_reg > CFG_W'(LIM)) ? CFG_W'(LIM) : rows_reg;
    assign dim_eff  = (dim_reg  > CFG_W'(LIM)) ? CFG_W'(LIM) : dim_reg;

    logic in_range;
    assign in_range = (32'(in_word.row) < MAX_DIM) && (32'(in_word.col) < MAX_DIM);

    // A store here; B rows and C columns live in the cells.
    logic [OPND_W-1:0] mem_a [MAX_DIM][MAX_DIM];

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [MW-1:0] r_reg;
    logic accept;
    assign accept = start && !busy;

    cell_ctrl_t ctrl;
    logic seed_phase;

    // Load address into a cell bank: column for B, row for C.
    logic [MW-1:0] ld_addr;
    logic [MW-1:0] c_addr;
    assign ld_addr = (in_word.opcode == OP_LOAD_B) ? MW'(in_word.col) : MW'(in_word.row);
    // Seed read is issued at the accept edge, so idle reads follow the input row.
    assign c_addr  = busy ? r_reg : MW'(in_word.row);

    // A feed: A[k] read at cnt = k, presented at cnt = k + 1 while k < dim.
    logic signed [OPND_W-1:0] a_feed;
    logic signed [OPND_W-1:0] a_q;

    logic signed [OPND_W-1:0] a_chain [MAX_DIM+1];
    logic signed [ACC_W-1:0]  acc_chain [MAX_DIM+1];
    logic [MW-1:0] drain_col;

    always_comb
    begin
        a_feed = '0;
        if (state_reg == ST_MAC && cnt_reg >= CW'(1) && cnt_reg <= CW'(dim_eff))
            a_feed = a_q;
    end
    assign a_chain[0] = a_feed;
    assign acc_chain[MAX_DIM] = '0;

    // Per-cell inner index: cell j sees A element k at cnt = k + 1 + j,
    // and reads B[j][k] in the cycle before.
    genvar g;
    generate
        for (g = 0; g < MAX_DIM; g++)
        begin : g_cell
            logic [CW-1:0] rk;
            logic [CW-1:0] kj;
            logic          act;
            logic          ld_b;
            logic          ld_c;
            logic          wb;
            cell_ctrl_t    cc;
            assign rk   = cnt_reg - CW'(g);
            assign kj   = rk - CW'(1);
            assign act  = (state_reg == ST_MAC) && (cnt_reg >= CW'(1 + g))
                          && (kj < CW'(dim_eff));
            assign ld_b = accept && in_range && (in_word.opcode == OP_LOAD_B)
                          && (32'(in_word.row) == g);
            assign ld_c = accept && in_range && (in_word.opcode == OP_LOAD_C)
                          && (32'(in_word.col) == g);
            assign wb   = (state_reg == ST_DRAIN) && (cnt_reg == '0)
                          && (CW'(g) < CW'(dim_eff));
            assign cc.clear = ctrl.clear;
            assign cc.mac   = act;
            assign cc.shift = ctrl.shift;
            mma_cell #(.MAX_DIM(MAX_DIM), .AW(MW)) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (cc),
                .ld_b    (ld_b),
                .ld_c    (ld_c),
                .wb      (wb),
                .ld_addr (ld_addr),
                .ld_value(in_word.value),
                .b_addr  (rk[MW-1:0]),
                .c_addr  (c_addr),
                .a_in    (a_chain[g]),
                .acc_in  (acc_chain[g+1]),
                .a_out   (a_chain[g+1]),
                .acc_out (acc_chain[g])
            );
        end
    endgenerate

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ctrl       = '0;
        seed_phase = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_word.opcode == OP_COMPUTE
                    && 5'(in_word.row) < rows_eff && dim_eff != '0)
                begin
                    state_next = ST_MAC;
                    cnt_next   = '0;
                end
            end
            ST_MAC:
            begin
                if (cnt_reg == '0)
                begin
                    ctrl.clear = 1'b1;
                    seed_phase = 1'b1;
                end
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(dim_eff) + CW'(MAX_DIM - 1))
                begin
                    state_next = ST_DRAIN;
                    cnt_next   = '0;
                end
            end
            ST_DRAIN:
            begin
                ctrl.shift = 1'b1;
                cnt_next   = cnt_reg + CW'(1);
                if (cnt_reg == CW'(dim_eff) - CW'(1))
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign drain_col = cnt_reg[MW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            r_reg <= MW'(in_word.row);
    end

    // A store: load writes, one registered read a cycle for the feed.
    always_ff @(posedge clk)
    begin
        if (accept && in_range && in_word.opcode == OP_LOAD_A)
            mem_a[MW'(in_word.row)][MW'(in_word.col)] <= in_word.value;
        a_q <= mem_a[r_reg][cnt_reg[MW-1:0]];
    end

    assign busy = (state_reg != ST_IDLE);

    // Output: cell 0 holds the next column in drain order.
    always_comb
    begin
        out_valid          = (state_reg == ST_DRAIN);
        out_word.out_row   = IDX_W'(r_reg);
        out_word.out_col   = IDX_W'(drain_col);
        out_word.out_value = acc_chain[0];
        out_word.last      = (cnt_reg == CW'(dim_eff) - CW'(1));
    end

    // Checks.
    a_no_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> busy)
        else $error("result strobe while idle");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.last) |=> !busy)
        else $error("block still busy after last word");
    a_seed_once: assert property (@(posedge clk) disable iff (!rst_n)
        seed_phase |=> !seed_phase)
        else $error("accumulator seeded twice");
endmodule
